// File: sv/clb_pkg.sv
// Shared types, constants and register codes for the contact Laplacian builder.
// Used by clb_dist_unit and contact_laplacian_builder_unit; depends on nothing.
package clb_pkg;

   localparam int MAX_POINTS = 256;
   localparam int COORD_BITS = 20;

   localparam int IDX_W    = $clog2(MAX_POINTS);
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int POINT_W  = 3 * COORD_BITS;
   localparam int ABS_W    = COORD_BITS + 1;
   localparam int SQ_W     = 2 * ABS_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int CUTOFF_W = 44;
   localparam int CMP_W    = (SUM_W > CUTOFF_W) ? SUM_W : CUTOFF_W;

   localparam int FIELD_COORD_W = 20;
   localparam int FIELD_INDEX_W = 8;
   localparam int ENTRY_W       = 9;
   localparam int PIDX_W        = 8;
   localparam int PCNT_W        = 9;
   localparam int DEG_W         = ENTRY_W - 1;

   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(514089);
   localparam logic signed [ENTRY_W-1:0] ENTRY_CONTACT = -ENTRY_W'(1);
   localparam logic signed [ENTRY_W-1:0] ENTRY_NONE = '0;
   localparam logic [DEG_W-1:0] DEG_MAX = '1;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam logic REG_CUTOFF = 1'b0;

   typedef struct packed {
      logic [1:0]                      func;
      logic signed [FIELD_COORD_W-1:0] x_coord;
      logic signed [FIELD_COORD_W-1:0] y_coord;
      logic signed [FIELD_COORD_W-1:0] z_coord;
      logic [FIELD_INDEX_W-1:0]        row_index;
      logic [FIELD_INDEX_W-1:0]        col_index;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] entry_value;
      logic [PIDX_W-1:0]         point_index;
      logic [PCNT_W-1:0]         point_count;
      logic                      error;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic done;
      logic contact;
   } dist_stat_type;

endpackage

// File: sv/clb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the point store of the builder.
module clb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/clb_dist_unit.sv
// Shared squared-distance unit: one axis per cycle through difference, square
// and accumulate stages, then a compare against the cutoff. Uses clb_pkg.
module clb_dist_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  clb_pkg::point_type               a_point,
   input  clb_pkg::point_type               b_point,
   input  logic [clb_pkg::CUTOFF_W-1:0]     cutoff,
   output clb_pkg::dist_stat_type           status
);

   logic                            issue_ff, issue_in;
   logic [1:0]                      axis_ff, axis_in;
   logic                            v1_ff, first1_ff, last1_ff;
   logic [clb_pkg::ABS_W-1:0]       absd_ff;
   logic                            v2_ff, first2_ff, last2_ff;
   logic [clb_pkg::SQ_W-1:0]        sq_ff;
   logic [clb_pkg::SUM_W-1:0]       acc_ff;
   logic                            done_ff, contact_ff;

   logic signed [clb_pkg::COORD_BITS-1:0] a_sel, b_sel;
   logic signed [clb_pkg::ABS_W-1:0]      diff;
   logic [clb_pkg::ABS_W-1:0]             absd_in;
   logic [clb_pkg::SQ_W-1:0]              sq_in;
   logic [clb_pkg::SUM_W-1:0]             acc_base, sum_in;

   always_comb begin
      unique case (axis_ff)
         clb_pkg::AXIS_X: begin
            a_sel = a_point.x;
            b_sel = b_point.x;
         end
         clb_pkg::AXIS_Y: begin
            a_sel = a_point.y;
            b_sel = b_point.y;
         end
         default: begin
            a_sel = a_point.z;
            b_sel = b_point.z;
         end
      endcase
      diff     = clb_pkg::ABS_W'(a_sel) - clb_pkg::ABS_W'(b_sel);
      absd_in  = diff[clb_pkg::ABS_W-1] ? clb_pkg::ABS_W'(-diff) : clb_pkg::ABS_W'(diff);
      sq_in    = absd_ff * absd_ff;
      acc_base = first2_ff ? '0 : acc_ff;
      sum_in   = acc_base + clb_pkg::SUM_W'(sq_ff);
   end

   always_comb begin
      issue_in = issue_ff;
      axis_in  = axis_ff;
      if (start) begin
         issue_in = 1'b1;
         axis_in  = clb_pkg::AXIS_X;
      end else if (issue_ff) begin
         axis_in = axis_ff + 2'd1;
         if (axis_ff == clb_pkg::AXIS_Z) begin
            issue_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         v1_ff    <= issue_ff;
         v2_ff    <= v1_ff;
         done_ff  <= v2_ff && last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff   <= axis_in;
      first1_ff <= (axis_ff == clb_pkg::AXIS_X);
      last1_ff  <= (axis_ff == clb_pkg::AXIS_Z);
      absd_ff   <= absd_in;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      sq_ff     <= sq_in;
      if (v2_ff) begin
         acc_ff     <= sum_in;
         contact_ff <= clb_pkg::CMP_W'(sum_in) <= clb_pkg::CMP_W'(cutoff);
      end
   end

   assign status.done    = done_ff;
   assign status.contact = contact_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !issue_ff && !v1_ff && !v2_ff)
      else $error("Distance unit restarted while a check was in flight.");

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !v1_ff && !v2_ff)
      else $error("Distance unit reported done with axes still in the pipeline.");

   assert property (@(posedge clock) disable iff (reset) $rose(issue_ff) |=> issue_ff ##1 issue_ff)
      else $error("Distance unit issued fewer than three axes.");

endmodule

// File: sv/contact_laplacian_builder_unit.sv
// Top level of the contact Laplacian builder: sequencer, point store and CSR.
// Depends on clb_pkg, clb_ram and clb_dist_unit.
//
//   port group   direction   protocol      word
//   req_*        in          valid/ready   clb_pkg::req_type
//   rsp_*        out         valid/ready   clb_pkg::rsp_type
//   p* (APB)     in/out      APB, 64-bit   cutoff_sq at address 0
//
// Clear, append and unused codes pass from acceptance through S_DONE to the output register.
// An off-diagonal read runs one distance check; a diagonal read runs one per stored point.
// Each distance check occupies the shared distance unit and the store read port.
// Reset empties the store at once by zeroing the count; cutoff returns to 514089.
// A new word is taken while the previous result waits in the output register.
module contact_laplacian_builder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  clb_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output clb_pkg::rsp_type                   rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [clb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [clb_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [clb_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_ROW_WAIT  = 7'b0000010,
      S_ROW_LATCH = 7'b0000100,
      S_COL_WAIT  = 7'b0001000,
      S_START     = 7'b0010000,
      S_BUSY      = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [clb_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [clb_pkg::CUTOFF_W-1:0]      cutoff_ff, cutoff_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   clb_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic signed [clb_pkg::ENTRY_W-1:0] res_entry_ff, res_entry_in;
   logic [clb_pkg::PIDX_W-1:0]        res_pidx_ff, res_pidx_in;
   logic                              res_err_ff, res_err_in;
   clb_pkg::point_type                row_pt_ff, row_pt_in;
   logic [clb_pkg::IDX_W-1:0]         ram_addr_ff, ram_addr_in;
   logic [clb_pkg::IDX_W-1:0]         j_ff, j_in;
   logic [clb_pkg::IDX_W-1:0]         row_ff, row_in;
   logic [clb_pkg::IDX_W-1:0]         col_ff, col_in;
   logic [clb_pkg::DEG_W-1:0]         deg_ff, deg_in;
   logic                              diag_ff, diag_in;

   logic                              accept, out_load, cfg_write;
   logic                              ram_we;
   clb_pkg::point_type                ram_wr_point, ram_rd_point;
   logic [clb_pkg::POINT_W-1:0]       ram_rd_data;
   logic                              dist_start;
   clb_pkg::dist_stat_type            dist_stat;
   logic                              last_j;
   logic [clb_pkg::DEG_W-1:0]         deg_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign cfg_write = psel && penable && pwrite && pready;
   assign dist_start = (state_ff == S_START);

   assign ram_wr_point.x = clb_pkg::COORD_BITS'(req_data.x_coord);
   assign ram_wr_point.y = clb_pkg::COORD_BITS'(req_data.y_coord);
   assign ram_wr_point.z = clb_pkg::COORD_BITS'(req_data.z_coord);
   assign ram_rd_point   = clb_pkg::point_type'(ram_rd_data);

   assign last_j = (clb_pkg::CNT_W'(j_ff) + clb_pkg::CNT_W'(1)) == count_ff;
   assign deg_next = (dist_stat.contact && (j_ff != row_ff) && (deg_ff != clb_pkg::DEG_MAX))
                     ? deg_ff + clb_pkg::DEG_W'(1) : deg_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      res_entry_in = res_entry_ff;
      res_pidx_in  = res_pidx_ff;
      res_err_in   = res_err_ff;
      row_pt_in    = row_pt_ff;
      ram_addr_in  = ram_addr_ff;
      j_in         = j_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      deg_in       = deg_ff;
      diag_in      = diag_ff;
      ram_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_entry_in = clb_pkg::ENTRY_NONE;
               res_pidx_in  = '0;
               res_err_in   = 1'b0;
               deg_in       = '0;
               state_in     = S_DONE;
               unique case (req_data.func)
                  clb_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  clb_pkg::FUNC_APPEND: begin
                     if (count_ff == clb_pkg::CNT_W'(clb_pkg::MAX_POINTS)) begin
                        res_err_in = 1'b1;
                     end else begin
                        ram_we      = 1'b1;
                        res_pidx_in = clb_pkg::PIDX_W'(count_ff);
                        count_in    = count_ff + clb_pkg::CNT_W'(1);
                     end
                  end
                  clb_pkg::FUNC_READ: begin
                     if ((32'(req_data.row_index) >= 32'(count_ff)) ||
                         (32'(req_data.col_index) >= 32'(count_ff))) begin
                        res_err_in = 1'b1;
                     end else begin
                        ram_addr_in = clb_pkg::IDX_W'(req_data.row_index);
                        row_in      = clb_pkg::IDX_W'(req_data.row_index);
                        col_in      = clb_pkg::IDX_W'(req_data.col_index);
                        diag_in     = (req_data.row_index == req_data.col_index);
                        state_in    = S_ROW_WAIT;
                     end
                  end
                  default: begin
                     res_err_in = 1'b1;
                  end
               endcase
            end
         end
         S_ROW_WAIT: begin
            state_in = S_ROW_LATCH;
         end
         S_ROW_LATCH: begin
            row_pt_in   = ram_rd_point;
            ram_addr_in = diag_ff ? '0 : col_ff;
            j_in        = '0;
            state_in    = S_COL_WAIT;
         end
         S_COL_WAIT: begin
            state_in = S_START;
         end
         S_START: begin
            state_in = S_BUSY;
         end
         S_BUSY: begin
            if (dist_stat.done) begin
               if (!diag_ff) begin
                  res_entry_in = dist_stat.contact ? clb_pkg::ENTRY_CONTACT : clb_pkg::ENTRY_NONE;
                  state_in     = S_DONE;
               end else begin
                  deg_in = deg_next;
                  if (last_j) begin
                     res_entry_in = clb_pkg::ENTRY_W'(deg_next);
                     state_in     = S_DONE;
                  end else begin
                     j_in        = j_ff + clb_pkg::IDX_W'(1);
                     ram_addr_in = j_ff + clb_pkg::IDX_W'(1);
                     state_in    = S_COL_WAIT;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.entry_value = res_entry_ff;
         rsp_data_in.point_index = res_pidx_ff;
         rsp_data_in.point_count = clb_pkg::PCNT_W'(count_ff);
         rsp_data_in.error       = res_err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cutoff_in = cutoff_ff;
      if (cfg_write && (paddr[3] == clb_pkg::REG_CUTOFF)) begin
         cutoff_in = pwdata[clb_pkg::CUTOFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cutoff_ff    <= clb_pkg::CUTOFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cutoff_ff    <= cutoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      res_entry_ff <= res_entry_in;
      res_pidx_ff  <= res_pidx_in;
      res_err_ff   <= res_err_in;
      row_pt_ff    <= row_pt_in;
      ram_addr_ff  <= ram_addr_in;
      j_ff         <= j_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      deg_ff       <= deg_in;
      diag_ff      <= diag_in;
   end

   clb_ram #(
      .DATA_W(clb_pkg::POINT_W),
      .DEPTH (clb_pkg::MAX_POINTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(clb_pkg::IDX_W'(count_ff)),
      .wr_data(ram_wr_point),
      .rd_addr(ram_addr_ff),
      .rd_data(ram_rd_data)
   );

   clb_dist_unit u_dist (
      .clock  (clock),
      .reset  (reset),
      .start  (dist_start),
      .a_point(row_pt_ff),
      .b_point(ram_rd_point),
      .cutoff (cutoff_ff),
      .status (dist_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[3] == clb_pkg::REG_CUTOFF) ? clb_pkg::CSR_DATA_W'(cutoff_ff) : '0;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= clb_pkg::CNT_W'(clb_pkg::MAX_POINTS))
      else $error("Point count ran past the store depth.");

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE) && (req_data.func == clb_pkg::FUNC_APPEND))
      else $error("Point store written outside an accepted append.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> !dist_stat.done)
      else $error("Distance check started while a previous result was pending.");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_BUSY) && !dist_stat.done) |=> $stable(ram_addr_ff) && $stable(row_pt_ff))
      else $error("Distance operands changed during a check.");

endmodule
